### rtl/pcpa_pkg.sv
`default_nettype none

package pcpa_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COMP_W     = 4;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MARGIN_W   = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned REPL_W     = 16;
  localparam int unsigned TREND_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEACTIVATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVALUATE   = 2'd2;

  // adaptation modes
  localparam logic [MODE_W-1:0] MODE_REL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLICA = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUB    = 2'd3;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd51200;
  localparam logic [24:0]         ONE_Q      = 25'd65536;
  localparam logic [RATE_W-1:0]   RATE_MAX   = 24'hFFFFFF;
  localparam logic [REPL_W-1:0]   REPL_MAX   = 16'hFFFF;
  localparam logic [REPL_W-1:0]   REPL_ONE   = 16'd1;
  localparam logic [RATE_W-1:0]   REL_LO     = 24'd6554;
  localparam logic [RATE_W-1:0]   REL_HI     = 24'd2621440;
  localparam logic [RATE_W-1:0]   COST_LO    = 24'd32768;
  localparam logic [RATE_W-1:0]   COST_HI    = 24'd1638400;

  // floor(2^32 / 25): quotient estimate is low by at most one
  localparam logic [27:0]         DIV25_RECIP = 28'd171798691;
  localparam logic [30:0]         DIV_STEP    = 31'd25;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain;
    logic [RATE_W-1:0]         rate;
    logic [REPL_W-1:0]         repl;
    logic signed [TREND_W-1:0] trend;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } st_e;

endpackage

`default_nettype wire

### rtl/pcpa_if.sv
`default_nettype none

interface pcpa_req_if;
  import pcpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COMP_W-1:0]   component;
  logic [RATE_W-1:0]   start_rate;
  logic [RATE_W-1:0]   measured;

  modport source(output valid, kind, component, start_rate, measured, input ready);
  modport sink(input valid, kind, component, start_rate, measured, output ready);
endinterface

interface pcpa_rsp_if;
  import pcpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [COMP_W-1:0]   out_component;
  logic                adapt_valid;
  logic                adapt_kind;
  logic [RATE_W-1:0]   adapt_value;
  logic                exception_valid;
  logic                exception_up;
  logic                error_flag;

  modport source(output valid, out_component, adapt_valid, adapt_kind, adapt_value,
                 exception_valid, exception_up, error_flag, input ready);
  modport sink(input valid, out_component, adapt_valid, adapt_kind, adapt_value,
               exception_valid, exception_up, error_flag, output ready);
endinterface

`default_nettype wire

### rtl/per_component_proportional_adapter_unit.sv
// Items pass one at a time through the four-step read-multiply-divide-update sequence
// around the single-port entry memory: the input transfer reads the entry, and the
// update step loads the output register; a held result stalls the update step.
// Reset: rst_ni clears the sequencer, the output valid, the active bits and the
// configuration registers; entry memory is not reset and an entry is loaded by activate.
`default_nettype none

module per_component_proportional_adapter_unit #(
  parameter int unsigned COMPONENTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pcpa_req_if.sink                          req_i,
  pcpa_rsp_if.source                        rsp_o
);
  import pcpa_pkg::*;

  localparam int unsigned AW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // configuration
  logic [GAIN_W-1:0]   gain_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [MODE_W-1:0]   mode_q;
  logic [COMP_W-1:0]   hub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      margin_q <= '0;
      mode_q   <= MODE_REL;
      hub_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_MARGIN: margin_q <= cfg_data_i[MARGIN_W-1:0];
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_HUB:    hub_q    <= cfg_data_i[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  st_e  state_q, state_d;
  logic in_ready;
  logic upd_fire;
  logic out_free;
  logic out_valid_q;
  logic accept;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign accept   = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_i.valid) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_UPD;
      ST_UPD:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    upd_fire = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_UPD:  upd_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  logic [KIND_W-1:0] kind_q;
  logic [COMP_W-1:0] comp_q;
  logic [AW-1:0]     addr_q;
  logic [RATE_W-1:0] start_q;
  logic [RATE_W-1:0] meas_q;
  logic              in_range_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= req_i.kind;
      comp_q     <= req_i.component;
      addr_q     <= AW'(req_i.component);
      start_q    <= req_i.start_rate;
      meas_q     <= req_i.measured;
      in_range_q <= (int'(req_i.component) < int'(COMPONENTS));
    end
  end

  // entry memory: read on the input transfer, written back in the update step
  entry_t mem [COMPONENTS];
  entry_t rd_q;
  entry_t wdata;
  logic   mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= wdata;
    end
    if (accept) begin
      rd_q <= mem[AW'(req_i.component)];
    end
  end

  // active bits
  logic [COMPONENTS-1:0] active_q;
  logic                  act_set, act_clr;
  logic                  act_hit;

  assign act_hit = active_q[addr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (upd_fire) begin
      if (act_set) active_q[addr_q] <= 1'b1;
      if (act_clr) active_q[addr_q] <= 1'b0;
    end
  end

  // multiply step: error, deviation test, gain * error
  logic [24:0]        ref_v;
  logic signed [24:0] err;
  logic [24:0]        aerr;
  logic               deviate;
  logic signed [41:0] prod;
  logic signed [41:0] prod_q;
  logic               dev_q;
  logic               err_pos_q;

  always_comb begin
    ref_v   = (mode_q == MODE_REL) ? ONE_Q : '0;
    err     = $signed(ref_v) - $signed({1'b0, meas_q});
    aerr    = err[24] ? 25'(-err) : 25'(err);
    deviate = (mode_q == MODE_REL) ? (aerr > {9'b0, margin_q}) : (meas_q != '0);
    prod    = $signed({1'b0, rd_q.gain}) * err;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q    <= prod;
      dev_q     <= deviate;
      err_pos_q <= !err[24] && (err != '0);
    end
  end

  // divide step: floor(prod / 1024) / 25 by reciprocal, replica step by shift
  logic signed [31:0] xs;
  logic [30:0]        n;
  logic [58:0]        mprod;
  logic signed [41:0] rbias;
  logic [30:0]        n_q;
  logic               neg_q;
  logic [26:0]        q0_q;
  logic signed [17:0] rstep_q;

  always_comb begin
    xs    = prod_q[41:10];
    n     = xs[31] ? 31'(-xs) : 31'(xs);
    mprod = 59'(n) * 59'(DIV25_RECIP);
    rbias = err_pos_q ? (prod_q + 42'sd16777215) : prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      n_q     <= n;
      neg_q   <= xs[31];
      q0_q    <= mprod[58:32];
      rstep_q <= rbias[41:24];
    end
  end

  // update step
  logic [30:0]        q25;
  logic [30:0]        rem;
  logic               fix;
  logic               rem_nz;
  logic [27:0]        qn;
  logic signed [27:0] step;
  logic signed [28:0] nr;
  logic signed [18:0] nc;
  logic [RATE_W-1:0]  lo, hi;
  logic signed [TREND_W-1:0] tc;
  logic signed [TREND_W-1:0] tc_new;
  logic               exc_up, exc_dn;

  always_comb begin
    q25    = 31'(q0_q) * DIV_STEP;
    rem    = n_q - q25;
    fix    = rem >= DIV_STEP;
    rem_nz = fix ? (rem != DIV_STEP) : (rem != '0);
    qn     = {1'b0, q0_q} + 28'(fix);
    step   = neg_q ? -$signed(qn + 28'(rem_nz)) : $signed(qn);
    nr     = $signed({5'b0, rd_q.rate}) + {step[27], step};
    nc     = $signed({3'b0, rd_q.repl}) + {rstep_q[17], rstep_q};
    lo     = (mode_q == MODE_REL) ? REL_LO : COST_LO;
    hi     = (mode_q == MODE_REL) ? REL_HI : COST_HI;

    // count consecutive deviating or stable evaluations
    if (dev_q) begin
      tc = (rd_q.trend < 0) ? 4'sd0 : rd_q.trend + 4'sd1;
    end else begin
      tc = (rd_q.trend > 0) ? 4'sd0 : rd_q.trend - 4'sd1;
    end
    exc_up = tc > 4'sd4;
    exc_dn = tc < -4'sd4;
    tc_new = (exc_up || exc_dn) ? 4'sd0 : tc;
  end

  logic              a_valid, a_kind;
  logic [RATE_W-1:0] a_value;
  entry_t            ent_new;

  always_comb begin
    ent_new       = rd_q;
    ent_new.trend = tc_new;
    a_valid       = 1'b0;
    a_kind        = 1'b0;
    a_value       = '0;
    if (dev_q) begin
      if (comp_q == hub_q) begin
        if (nr > 29'sd0) begin
          ent_new.rate = (nr > $signed({5'b0, RATE_MAX})) ? RATE_MAX : nr[RATE_W-1:0];
          a_valid      = 1'b1;
          a_value      = ent_new.rate;
        end
      end else if (mode_q == MODE_REPLICA) begin
        if (nc < 19'sd1) begin
          ent_new.repl = REPL_ONE;
        end else if (nc > $signed({3'b0, REPL_MAX})) begin
          ent_new.repl = REPL_MAX;
        end else begin
          ent_new.repl = nc[REPL_W-1:0];
        end
        a_valid = 1'b1;
        a_kind  = 1'b1;
        a_value = RATE_W'(ent_new.repl);
      end else if (nr >= $signed({5'b0, lo}) && nr <= $signed({5'b0, hi})) begin
        ent_new.rate = nr[RATE_W-1:0];
        a_valid      = 1'b1;
        a_value      = ent_new.rate;
      end
    end
  end

  logic              r_a_valid, r_a_kind, r_e_valid, r_e_up, r_err;
  logic [RATE_W-1:0] r_a_value;

  always_comb begin
    mem_we    = 1'b0;
    wdata     = ent_new;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    r_a_valid = 1'b0;
    r_a_kind  = 1'b0;
    r_a_value = '0;
    r_e_valid = 1'b0;
    r_e_up    = 1'b0;
    r_err     = 1'b0;
    case (kind_q)
      KIND_ACTIVATE: begin
        if (in_range_q) begin
          mem_we  = upd_fire;
          wdata   = '{gain: gain_q, rate: start_q, repl: REPL_ONE, trend: 4'sd0};
          act_set = 1'b1;
        end
      end
      KIND_DEACTIVATE: begin
        act_clr = in_range_q;
      end
      KIND_EVALUATE: begin
        if (!in_range_q || !act_hit) begin
          r_err = 1'b1;
        end else begin
          mem_we    = upd_fire;
          r_a_valid = a_valid;
          r_a_kind  = a_kind;
          r_a_value = a_value;
          r_e_valid = exc_up || exc_dn;
          r_e_up    = exc_up;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic [COMP_W-1:0] o_comp_q;
  logic              o_a_valid_q, o_a_kind_q, o_e_valid_q, o_e_up_q, o_err_q;
  logic [RATE_W-1:0] o_a_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      o_comp_q    <= comp_q;
      o_a_valid_q <= r_a_valid;
      o_a_kind_q  <= r_a_kind;
      o_a_value_q <= r_a_value;
      o_e_valid_q <= r_e_valid;
      o_e_up_q    <= r_e_up;
      o_err_q     <= r_err;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.out_component   = o_comp_q;
  assign rsp_o.adapt_valid     = o_a_valid_q;
  assign rsp_o.adapt_kind      = o_a_kind_q;
  assign rsp_o.adapt_value     = o_a_value_q;
  assign rsp_o.exception_valid = o_e_valid_q;
  assign rsp_o.exception_up    = o_e_up_q;
  assign rsp_o.error_flag      = o_err_q;

`ifndef ASSERT_OFF
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result appeared without an update step");

  a_command_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.adapt_valid) |-> (rsp_o.adapt_value != '0))
    else $error("adaptation command with zero value");

  a_error_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.error_flag) |-> (!rsp_o.adapt_valid && !rsp_o.exception_valid))
    else $error("error result carries a command or exception");

  a_replica_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.adapt_kind) |-> (rsp_o.adapt_value[23:16] == '0))
    else $error("replica count beyond 16 bits");
`endif

endmodule

`default_nettype wire
